// ===== design/rttwdp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rttwdp_pkg
// Shared types and constants of the rtt window drop probability block.
// ---------------------------------------------------------------------------
package rttwdp_pkg;

    localparam logic [0:0] CMD_SAMPLE = 1'b0;
    localparam logic [0:0] CMD_CHECK  = 1'b1;

    localparam logic [2:0] REG_WINDOW_SIZE   = 3'd0;
    localparam logic [2:0] REG_DROP_FACTOR   = 3'd1;
    localparam logic [2:0] REG_MIN_DROP      = 3'd2;
    localparam logic [2:0] REG_SMOOTHER      = 3'd3;
    localparam logic [2:0] REG_TIMEOUT_RATIO = 3'd4;
    localparam logic [2:0] REG_INITIAL_TIMER = 3'd5;
    localparam logic [2:0] REG_INITIAL_PROP  = 3'd6;
    localparam logic [2:0] REG_STALE_LIMIT   = 3'd7;

    localparam logic [6:0]  RST_WINDOW_SIZE   = 7'd30;
    localparam logic [15:0] RST_DROP_FACTOR   = 16'd328;
    localparam logic [15:0] RST_MIN_DROP      = 16'd1;
    localparam logic [15:0] RST_SMOOTHER      = 16'd6554;
    localparam logic [15:0] RST_TIMEOUT_RATIO = 16'd512;
    localparam logic [31:0] RST_TIMER         = 32'd65536000;
    localparam logic [15:0] RST_PROP_DELAY    = 16'd65535;
    localparam logic [31:0] RST_STALE_LIMIT   = 32'd2000000;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_END,
        ST_PROD,
        ST_TMUL,
        ST_TSUM,
        ST_DROP,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] quotient;
    } div_rsp_t;

endpackage

// ===== design/rttwdp_if.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rttwdp_if
// Valid/ready channels for samples and results.
// ---------------------------------------------------------------------------
interface rttwdp_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [15:0] rtt_ms;
    logic [31:0] now_us;

    modport source (output valid, command, rtt_ms, now_us, input ready);
    modport sink   (input valid, command, rtt_ms, now_us, output ready);
endinterface

interface rttwdp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] rtt_min_ms;
    logic [15:0] rtt_max_ms;
    logic [15:0] drop_prob_q16;
    logic [15:0] prop_delay_ms;
    logic        prop_delay_lowered;
    logic [31:0] timer_q16;
    logic        window_full;
    logic        stale;

    modport source (output valid, rtt_min_ms, rtt_max_ms, drop_prob_q16, prop_delay_ms,
                    prop_delay_lowered, timer_q16, window_full, stale, input ready);
    modport sink   (input valid, rtt_min_ms, rtt_max_ms, drop_prob_q16, prop_delay_ms,
                    prop_delay_lowered, timer_q16, window_full, stale, output ready);
endinterface

// ===== design/rttwdp_ring.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rttwdp_ring
// Sample ring memory with one write port and one registered read port.
// ---------------------------------------------------------------------------
module rttwdp_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [15:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [15:0]   rd_data
);

    logic [15:0] mem [DEPTH];
    logic [15:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== design/rttwdp_div.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rttwdp_div
// Restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
// ---------------------------------------------------------------------------
module rttwdp_div (
    input  logic                clk,
    input  logic                rst_n,
    input  rttwdp_pkg::div_req_t req,
    output rttwdp_pkg::div_rsp_t rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] quo_reg, quo_next;
    logic [15:0] den_reg, den_next;
    logic [16:0] trial;
    logic        ge;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    always_comb
    begin
        trial     = {rem_reg, quo_reg[31]};
        ge        = trial >= {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
            quo_next = {quo_reg[30:0], ge};
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

// ===== design/rtt_window_drop_probability.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// rtt_window_drop_probability
// Windowed min/max rtt filter with drop probability and timeout timer.
// ---------------------------------------------------------------------------
// The sample channel takes one command per transfer: a new rtt sample or a
// staleness check. Each command gives exactly one transfer on the result
// channel. Configuration is to be written through cfg_wr_en, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
// A sample rescans the newest entries of the ring, one memory read per
// cycle, then runs the timer multiplies and the divider for the drop
// probability. A check skips the scan and the timer steps. Without a full
// window, or with max equal to min, the divide is skipped. The block takes
// the next command in the cycle after the load of the result register,
// even while that result still waits.
// When the receiver stalls, the result holds and the next command waits in
// its final step until the result register is free.
// Reset empties the window, loads the default registers, the default timer
// and the default propagation delay; the ring needs no clearing pass.
// ---------------------------------------------------------------------------
module rtt_window_drop_probability #(
    parameter int WINDOW_MAX = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    rttwdp_in_if.sink           sample,
    rttwdp_out_if.source        result
);

    localparam int AW = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int CW = $clog2(WINDOW_MAX + 1);

    rttwdp_pkg::state_t state_reg, state_next;

    logic [6:0]  window_size_reg;
    logic [15:0] drop_factor_reg, min_drop_reg, smoother_reg, ratio_reg;
    logic [31:0] stale_limit_reg;

    logic [AW-1:0] wp_reg, wp_next, rp_reg, rp_next;
    logic [CW-1:0] fill_reg, fill_next, idx_reg, idx_next;
    logic [15:0]   last_rtt_reg, last_rtt_next;
    logic [15:0]   min_reg, min_next, max_reg, max_next;
    logic [15:0]   prop_reg, prop_next;
    logic [31:0]   timer_reg, timer_next;
    logic [31:0]   last_time_reg, last_time_next;
    logic          rdv_reg, rdv_next;
    logic          cmd_reg, cmd_next;
    logic [15:0]   rtt_reg, rtt_next;
    logic [31:0]   now_reg, now_next;
    logic          lowered_reg, lowered_next;
    logic          stale_reg, stale_next;
    logic          full_reg, full_next;
    logic [31:0]   prod_reg, prod_next;
    logic [48:0]   p1_reg, p1_next;
    logic [31:0]   t_reg, t_next;
    logic [47:0]   p2_reg, p2_next;
    logic [15:0]   drop_reg, drop_next;

    logic          ov_reg, ov_next;
    logic [15:0]   o_min_reg, o_max_reg, o_drop_reg, o_prop_reg;
    logic          o_low_reg, o_full_reg, o_stale_reg;
    logic [31:0]   o_timer_reg;
    logic          load_out;

    logic          ring_wr, ring_rd;
    logic [15:0]   ring_q;
    logic [8:0]    ws9;
    logic [CW-1:0] n_eff, cnt;
    logic [56:0]   acc;
    logic [40:0]   acc_sh;
    logic [32:0]   drop_sum;
    logic [31:0]   age;

    rttwdp_pkg::div_req_t div_req;
    rttwdp_pkg::div_rsp_t div_rsp;

    rttwdp_ring #(
        .DEPTH (WINDOW_MAX),
        .AW    (AW)
    ) u_ring (
        .clk     (clk),
        .wr_en   (ring_wr),
        .wr_addr (wp_reg),
        .wr_data (sample.rtt_ms),
        .rd_en   (ring_rd),
        .rd_addr (rp_reg),
        .rd_data (ring_q)
    );

    rttwdp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= rttwdp_pkg::RST_WINDOW_SIZE;
            drop_factor_reg <= rttwdp_pkg::RST_DROP_FACTOR;
            min_drop_reg    <= rttwdp_pkg::RST_MIN_DROP;
            smoother_reg    <= rttwdp_pkg::RST_SMOOTHER;
            ratio_reg       <= rttwdp_pkg::RST_TIMEOUT_RATIO;
            stale_limit_reg <= rttwdp_pkg::RST_STALE_LIMIT;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                rttwdp_pkg::REG_WINDOW_SIZE:   window_size_reg <= cfg_data[6:0];
                rttwdp_pkg::REG_DROP_FACTOR:   drop_factor_reg <= cfg_data[15:0];
                rttwdp_pkg::REG_MIN_DROP:      min_drop_reg    <= cfg_data[15:0];
                rttwdp_pkg::REG_SMOOTHER:      smoother_reg    <= cfg_data[15:0];
                rttwdp_pkg::REG_TIMEOUT_RATIO: ratio_reg       <= cfg_data[15:0];
                rttwdp_pkg::REG_STALE_LIMIT:   stale_limit_reg <= cfg_data;
                default:                       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rttwdp_pkg::ST_IDLE;
            wp_reg        <= '0;
            fill_reg      <= '0;
            last_rtt_reg  <= '0;
            min_reg       <= '0;
            max_reg       <= '0;
            prop_reg      <= rttwdp_pkg::RST_PROP_DELAY;
            timer_reg     <= rttwdp_pkg::RST_TIMER;
            last_time_reg <= '0;
            rdv_reg       <= 1'b0;
            ov_reg        <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            last_rtt_reg  <= last_rtt_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            prop_reg      <= prop_next;
            timer_reg     <= timer_next;
            last_time_reg <= last_time_next;
            rdv_reg       <= rdv_next;
            ov_reg        <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg      <= rp_next;
        idx_reg     <= idx_next;
        cmd_reg     <= cmd_next;
        rtt_reg     <= rtt_next;
        now_reg     <= now_next;
        lowered_reg <= lowered_next;
        stale_reg   <= stale_next;
        full_reg    <= full_next;
        prod_reg    <= prod_next;
        p1_reg      <= p1_next;
        t_reg       <= t_next;
        p2_reg      <= p2_next;
        drop_reg    <= drop_next;
        if (load_out)
        begin
            o_min_reg   <= min_reg;
            o_max_reg   <= max_reg;
            o_drop_reg  <= drop_reg;
            o_prop_reg  <= prop_reg;
            o_low_reg   <= lowered_reg;
            o_timer_reg <= timer_reg;
            o_full_reg  <= full_reg;
            o_stale_reg <= stale_reg;
        end
    end

    always_comb
    begin
        ws9 = {2'b00, window_size_reg};
        if (ws9 == 9'd0)
        begin
            n_eff = CW'(1);
        end
        else if (ws9 > 9'(WINDOW_MAX))
        begin
            n_eff = CW'(WINDOW_MAX);
        end
        else
        begin
            n_eff = CW'(ws9);
        end
        cnt = (fill_reg < n_eff) ? fill_reg : n_eff;
    end

    assign acc      = {8'b0, p1_reg} + {1'b0, p2_reg, 8'b0};
    assign acc_sh   = acc[56:16];
    assign drop_sum = {17'b0, min_drop_reg} + {1'b0, div_rsp.quotient};
    assign age      = now_reg - last_time_reg;

    always_comb
    begin
        state_next     = state_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        last_rtt_next  = last_rtt_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        prop_next      = prop_reg;
        timer_next     = timer_reg;
        last_time_next = last_time_reg;
        rdv_next       = 1'b0;
        cmd_next       = cmd_reg;
        rtt_next       = rtt_reg;
        now_next       = now_reg;
        lowered_next   = lowered_reg;
        stale_next     = stale_reg;
        full_next      = full_reg;
        prod_next      = prod_reg;
        p1_next        = p1_reg;
        t_next         = t_reg;
        p2_next        = p2_reg;
        drop_next      = drop_reg;
        ring_wr        = 1'b0;
        ring_rd        = 1'b0;
        load_out       = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = prod_reg;
        div_req.divisor  = max_reg - min_reg;
        sample.ready   = 1'b0;
        ov_next        = ov_reg && !result.ready;

        if (rdv_reg)
        begin
            if (ring_q < min_reg)
            begin
                min_next = ring_q;
            end
            if (ring_q > max_reg)
            begin
                max_next = ring_q;
            end
        end

        case (state_reg)
            rttwdp_pkg::ST_IDLE:
            begin
                sample.ready = 1'b1;
                if (sample.valid)
                begin
                    cmd_next = sample.command;
                    rtt_next = sample.rtt_ms;
                    now_next = sample.now_us;
                    if (sample.command == rttwdp_pkg::CMD_SAMPLE)
                    begin
                        ring_wr        = 1'b1;
                        last_rtt_next  = sample.rtt_ms;
                        last_time_next = sample.now_us;
                        rp_next        = wp_reg;
                        wp_next        = (wp_reg == AW'(WINDOW_MAX - 1)) ? '0 : wp_reg + 1'b1;
                        if (fill_reg < CW'(WINDOW_MAX))
                        begin
                            fill_next = fill_reg + 1'b1;
                        end
                        idx_next   = '0;
                        min_next   = 16'hFFFF;
                        max_next   = 16'h0000;
                        state_next = rttwdp_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = rttwdp_pkg::ST_PROD;
                    end
                end
            end

            rttwdp_pkg::ST_SCAN:
            begin
                ring_rd  = 1'b1;
                rdv_next = 1'b1;
                rp_next  = (rp_reg == '0) ? AW'(WINDOW_MAX - 1) : rp_reg - 1'b1;
                idx_next = idx_reg + 1'b1;
                if (idx_reg == cnt - 1'b1)
                begin
                    state_next = rttwdp_pkg::ST_SCAN_END;
                end
            end

            rttwdp_pkg::ST_SCAN_END:
            begin
                state_next = rttwdp_pkg::ST_PROD;
            end

            rttwdp_pkg::ST_PROD:
            begin
                lowered_next = 1'b0;
                if (cmd_reg == rttwdp_pkg::CMD_SAMPLE)
                begin
                    stale_next = 1'b0;
                    if (min_reg < prop_reg)
                    begin
                        prop_next    = min_reg;
                        lowered_next = 1'b1;
                    end
                    state_next = rttwdp_pkg::ST_TMUL;
                end
                else
                begin
                    stale_next = age > stale_limit_reg;
                    state_next = rttwdp_pkg::ST_DROP;
                end
                full_next = fill_reg >= n_eff;
                prod_next = drop_factor_reg *
                            ((last_rtt_reg > min_reg) ? last_rtt_reg - min_reg : 16'd0);
                p1_next   = (17'h10000 - {1'b0, smoother_reg}) * timer_reg;
                t_next    = rtt_reg * ratio_reg;
            end

            rttwdp_pkg::ST_TMUL:
            begin
                p2_next    = smoother_reg * t_reg;
                state_next = rttwdp_pkg::ST_TSUM;
            end

            rttwdp_pkg::ST_TSUM:
            begin
                timer_next = (acc_sh[40:32] != '0) ? 32'hFFFF_FFFF : acc_sh[31:0];
                state_next = rttwdp_pkg::ST_DROP;
            end

            rttwdp_pkg::ST_DROP:
            begin
                if (!full_reg)
                begin
                    drop_next  = '0;
                    state_next = rttwdp_pkg::ST_DONE;
                end
                else if (max_reg <= min_reg)
                begin
                    drop_next  = min_drop_reg;
                    state_next = rttwdp_pkg::ST_DONE;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = rttwdp_pkg::ST_DIV_WAIT;
                end
            end

            rttwdp_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    drop_next  = (drop_sum[32:16] != '0) ? 16'hFFFF : drop_sum[15:0];
                    state_next = rttwdp_pkg::ST_DONE;
                end
            end

            rttwdp_pkg::ST_DONE:
            begin
                if (!ov_reg || result.ready)
                begin
                    load_out   = 1'b1;
                    ov_next    = 1'b1;
                    state_next = rttwdp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rttwdp_pkg::ST_IDLE;
            end
        endcase
    end

    assign result.valid              = ov_reg;
    assign result.rtt_min_ms         = o_min_reg;
    assign result.rtt_max_ms         = o_max_reg;
    assign result.drop_prob_q16      = o_drop_reg;
    assign result.prop_delay_ms      = o_prop_reg;
    assign result.prop_delay_lowered = o_low_reg;
    assign result.timer_q16          = o_timer_reg;
    assign result.window_full        = o_full_reg;
    assign result.stale              = o_stale_reg;

    // The fill count never passes the ring depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(WINDOW_MAX))
        else $error("fill count beyond ring depth");

    // One command is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        sample.valid && sample.ready |=> !sample.ready)
        else $error("second transfer accepted while busy");

    // The propagation delay only ever goes down.
    assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> prop_reg <= $past(prop_reg))
        else $error("propagation delay increased");

    // A result is loaded only when the result register is free or drains.
    assert property (@(posedge clk) disable iff (!rst_n)
        load_out |-> !ov_reg || result.ready)
        else $error("result overwritten before transfer");

endmodule
